### rtl/afu_pkg.sv
// Shared types, function codes and lookup tables for the activation unit.
// Tables are built at elaboration from series and root routines; no deps.
package afu_pkg;

    localparam int FRAC_BITS = 12;
    localparam int TE        = 256;                 // table intervals
    localparam int TAB_AW    = $clog2(TE + 1);      // table index width
    localparam int LERP_SH   = 15 - $clog2(TE);     // fraction bits of |x| between points
    localparam int SH_Q      = 30 - FRAC_BITS;      // Q4.12 -> Q30
    localparam int SH_SQ     = 30 - 2 * FRAC_BITS;  // x^2 -> Q30
    localparam int SH_CUBE   = 3 * FRAC_BITS - 30;  // alpha*x^2 -> Q30

    localparam int DIV_QB    = 31;                  // quotient bits
    localparam int DIV_DW    = 37;                  // divisor width
    localparam int DIV_NEXP  = 60;                  // dividend is 2^60

    localparam logic [63:0] Q30      = 64'd1 << 30;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [30:0] HALF_PI  = 31'd1686629713;
    localparam logic [30:0] SELU_LAM = 31'd1128180534;
    localparam logic [30:0] SELU_LA  = 31'd1887739361;
    localparam logic [14:0] LEAKY_SLOPE = 15'd41;

    localparam logic [3:0] FN_IDENT = 4'd0;
    localparam logic [3:0] FN_SIG   = 4'd1;
    localparam logic [3:0] FN_TANH  = 4'd2;
    localparam logic [3:0] FN_ATAN  = 4'd3;
    localparam logic [3:0] FN_SOFT  = 4'd4;
    localparam logic [3:0] FN_ISRU  = 4'd5;
    localparam logic [3:0] FN_RELU  = 4'd6;
    localparam logic [3:0] FN_LEAKY = 4'd7;
    localparam logic [3:0] FN_PRELU = 4'd8;
    localparam logic [3:0] FN_ELU   = 4'd9;
    localparam logic [3:0] FN_SELU  = 4'd10;

    localparam logic [1:0] CFG_FSEL  = 2'd0;
    localparam logic [1:0] CFG_ALPHA = 2'd1;

    typedef logic [30:0] t_tab [0:TE];

    // per-item data carried down the pipe
    typedef struct packed {
        logic        neg;
        logic        der;
        logic [15:0] ax;
        logic [30:0] tval;   // interpolated exp/tanh/atan
        logic [31:0] m;      // ISRU normalized sum
        logic [2:0]  k;      // ISRU scale exponent
        logic [30:0] q;      // divider quotient
        logic [39:0] imag;   // ISRU magnitude
    } t_item;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
            if (b > v) b = b >> 2;
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // long division, one quotient bit per step
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[63:0], n[j]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] gen_exp(input logic [63:0] u);
        logic [63:0] v;
        logic [63:0] sum;
        logic [63:0] term;
        int s;
        s = 0;
        for (int j = 0; j < 64; j++)
            if ((u >> s) > (Q30 >> 1)) s = s + 1;
        v = u >> s;
        sum = Q30;
        term = Q30;
        for (int k = 1; k <= 20; k++) begin
            term = ((term * v) >> 30) / 64'(k);
            if ((k & 1) == 1) sum = sum - term;
            else sum = sum + term;
        end
        for (int j = 0; j < 64; j++)
            if (j < s) sum = (sum * sum) >> 30;
        return sum;
    endfunction

    function automatic logic [63:0] gen_atan(input logic [63:0] a_in);
        logic        flip;
        logic [63:0] a;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] sum;
        a = a_in;
        flip = a > Q30;
        if (flip) a = udiv64(Q30 << 30, a);
        for (int k = 0; k < 2; k++)
            a = udiv64(a << 30, Q30 + isqrt64((Q30 << 30) + a * a));
        z2 = (a * a) >> 30;
        p = a;
        sum = a;
        for (int k = 1; k <= 10; k++) begin
            p = (p * z2) >> 30;
            if ((k & 1) == 1) sum = sum - p / 64'(2 * k + 1);
            else sum = sum + p / 64'(2 * k + 1);
        end
        sum = sum << 2;
        return flip ? (64'(HALF_PI) - sum) : sum;
    endfunction

    function automatic t_tab build_exp();
        t_tab t;
        for (int i = 0; i <= TE; i++)
            t[i] = 31'(gen_exp((64'(i) << (45 - FRAC_BITS)) / 64'(TE)));
        return t;
    endfunction

    function automatic t_tab build_tanh();
        t_tab t;
        logic [63:0] e;
        logic [63:0] e2;
        for (int i = 0; i <= TE; i++) begin
            e = gen_exp((64'(i) << (45 - FRAC_BITS)) / 64'(TE));
            e2 = (e * e) >> 30;
            t[i] = 31'(udiv64((Q30 - e2) << 30, Q30 + e2));
        end
        return t;
    endfunction

    function automatic t_tab build_atan();
        t_tab t;
        for (int i = 0; i <= TE; i++)
            t[i] = 31'(gen_atan((64'(i) << (45 - FRAC_BITS)) / 64'(TE)));
        return t;
    endfunction

    function automatic t_tab build_rsq();
        t_tab t;
        logic [63:0] m;
        for (int i = 0; i <= TE; i++) begin
            m = Q30 + (64'd3 * Q30 * 64'(i)) / 64'(TE);
            t[i] = 31'(udiv64(Q30 << 30, isqrt64(m << 30)));
        end
        return t;
    endfunction

    localparam t_tab EXP_TAB  = build_exp();
    localparam t_tab TANH_TAB = build_tanh();
    localparam t_tab ATAN_TAB = build_atan();
    localparam t_tab RSQ_TAB  = build_rsq();

endpackage

### rtl/afu_front.sv
// Front end: magnitude, table lookup and interpolation, divisor and ISRU setup.
// Three register stages; uses afu_pkg.
module afu_front import afu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [15:0] i_x_value,
    input  logic               i_want_derivative,
    input  logic [3:0]         i_fsel,
    input  logic [14:0]        i_alpha,
    output logic               o_vld,
    output t_item              o_item,
    output logic [DIV_DW-1:0]  o_divisor
);

    logic [2:0] r_vld;

    // stage 1
    logic [15:0]        w_raw, w_ax;
    logic [TAB_AW-1:0]  w_idx, w_idx1;
    logic [30:0]        w_ta, w_tb;
    logic               r1_neg, r1_der;
    logic [15:0]        r1_ax;
    logic [30:0]        r1_ta, r1_tb, r1_ax2;
    logic [LERP_SH-1:0] r1_frac;

    // stage 2
    logic        w_up;
    logic [30:0] w_diff, w_step;
    logic        r2_neg, r2_der;
    logic [15:0] r2_ax;
    logic [30:0] r2_tval, r2_ax2;
    logic [45:0] r2_isa;

    // stage 3
    logic [39:0]       w_s;
    logic [2:0]        w_k;
    t_item             n3_item, r3_item;
    logic [DIV_DW-1:0] n3_div, r3_div;

    always_comb begin
        w_raw  = i_x_value;
        w_ax   = w_raw[15] ? (16'd0 - w_raw) : w_raw;
        w_idx  = w_ax[15:LERP_SH];
        w_idx1 = (w_idx == TAB_AW'(TE)) ? w_idx : w_idx + TAB_AW'(1);
        case (i_fsel)
            FN_TANH: begin
                w_ta = TANH_TAB[w_idx];
                w_tb = TANH_TAB[w_idx1];
            end
            FN_ATAN: begin
                w_ta = ATAN_TAB[w_idx];
                w_tb = ATAN_TAB[w_idx1];
            end
            default: begin
                w_ta = EXP_TAB[w_idx];
                w_tb = EXP_TAB[w_idx1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg  <= w_raw[15];
            r1_der  <= i_want_derivative;
            r1_ax   <= w_ax;
            r1_ta   <= w_ta;
            r1_tb   <= w_tb;
            r1_frac <= w_ax[LERP_SH-1:0];
            r1_ax2  <= 31'(32'(w_ax) * 32'(w_ax));
        end
    end

    always_comb begin
        w_up   = r1_tb >= r1_ta;
        w_diff = w_up ? (r1_tb - r1_ta) : (r1_ta - r1_tb);
        w_step = 31'((38'(w_diff) * 38'(r1_frac)) >> LERP_SH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_neg  <= r1_neg;
            r2_der  <= r1_der;
            r2_ax   <= r1_ax;
            r2_tval <= w_up ? (r1_ta + w_step) : (r1_ta - w_step);
            r2_ax2  <= r1_ax2;
            r2_isa  <= 46'(i_alpha) * 46'(r1_ax2);
        end
    end

    // ISRU: scale 1 + alpha*x^2 by 4^-k into [1,4)
    always_comb begin
        w_s = 40'(ONE_Q30) + 40'(r2_isa >> SH_CUBE);
        if (w_s >= (40'd1 << 38))      w_k = 3'd4;
        else if (w_s >= (40'd1 << 36)) w_k = 3'd3;
        else if (w_s >= (40'd1 << 34)) w_k = 3'd2;
        else if (w_s >= (40'd1 << 32)) w_k = 3'd1;
        else                           w_k = 3'd0;

        n3_item      = '0;
        n3_item.neg  = r2_neg;
        n3_item.der  = r2_der;
        n3_item.ax   = r2_ax;
        n3_item.tval = r2_tval;
        n3_item.k    = w_k;
        n3_item.m    = 32'(w_s >> {w_k, 1'b0});

        case (i_fsel)
            FN_SIG:  n3_div = DIV_DW'(ONE_Q30) + DIV_DW'(r2_tval);
            FN_ATAN: n3_div = DIV_DW'(ONE_Q30) + (DIV_DW'(r2_ax2) << SH_SQ);
            FN_SOFT: n3_div = (DIV_DW'(r2_ax) + (DIV_DW'(1) << FRAC_BITS)) << SH_Q;
            default: n3_div = DIV_DW'(ONE_Q30);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_item <= n3_item;
            r3_div  <= n3_div;
        end
    end

    assign o_vld     = r_vld[2];
    assign o_item    = r3_item;
    assign o_divisor = r3_div;

endmodule

### rtl/afu_div.sv
// Pipelined restoring divider: 2^60 / divisor, one quotient bit per stage.
// Carries the item alongside; uses afu_pkg.
module afu_div import afu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_item             i_item,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_vld,
    output t_item             o_item
);

    logic [DIV_QB-1:0] r_vld;
    logic [DIV_DW:0]   r_rem [DIV_QB];
    logic [DIV_DW-1:0] r_dv  [DIV_QB];
    logic [DIV_QB-1:0] r_q   [DIV_QB];
    t_item             r_itm [DIV_QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_QB-2:0], i_vld};
        end
    end

    for (genvar s = 0; s < DIV_QB; s++) begin : g_stage
        logic [DIV_DW:0]   w_rem, w_two;
        logic [DIV_DW-1:0] w_dv;
        logic [DIV_QB-1:0] w_q;
        t_item             w_itm;

        if (s == 0) begin : g_first
            // remainder starts at the dividend bits above the quotient
            assign w_rem = (DIV_DW + 1)'(1) << (DIV_NEXP - DIV_QB);
            assign w_dv  = i_divisor;
            assign w_q   = '0;
            assign w_itm = i_item;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_dv  = r_dv[s-1];
            assign w_q   = r_q[s-1];
            assign w_itm = r_itm[s-1];
        end

        assign w_two = w_rem << 1;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_two >= {1'b0, w_dv}) begin
                    r_rem[s] <= w_two - {1'b0, w_dv};
                    r_q[s]   <= w_q | (DIV_QB'(1) << (DIV_QB - 1 - s));
                end else begin
                    r_rem[s] <= w_two;
                    r_q[s]   <= w_q;
                end
                r_dv[s]  <= w_dv;
                r_itm[s] <= w_itm;
            end
        end
    end

    always_comb begin
        o_item   = r_itm[DIV_QB-1];
        o_item.q = r_q[DIV_QB-1];
    end

    assign o_vld = r_vld[DIV_QB-1];

endmodule

### rtl/afu_isru.sv
// ISRU path: reciprocal square root by table and interpolation, then scaling.
// Seven register stages; uses afu_pkg.
module afu_isru import afu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic [6:0] r_vld;

    logic [31:0] w_d;
    logic [9:0]  w_t;
    logic [7:0]  w_i;
    t_item       r1_itm, r2_itm, r3_itm, r4_itm, r5_itm, r6_itm, r7_itm;
    t_item       n7_itm;
    logic [7:0]  r1_i;
    logic [31:0] r1_r, r2_r;
    logic [30:0] r2_ta, r2_tb;
    logic        w_up, r3_up, r4_up;
    logic [30:0] w_diff;
    logic [31:0] r3_p, r4_q3;
    logic [30:0] r3_ta, r4_ta, r5_rs, r6_rs, r6_c1;
    logic [46:0] r6_av;
    logic [4:0]  w_k3;
    logic [61:0] w_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_vld};
        end
    end

    // segment index = floor(256*(m-1)/3): top bits times 683/2048 gives exact /3
    always_comb begin
        w_d = i_item.m - 32'(ONE_Q30);
        w_t = w_d[31:22];
        w_i = 8'((20'(w_t) * 20'd683) >> 11);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_itm <= i_item;
            r1_i   <= w_i;
            r1_r   <= 32'((40'(w_d) << $clog2(TE)) - ((40'(w_i) * 40'd3) << 30));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_itm <= r1_itm;
            r2_r   <= r1_r;
            r2_ta  <= RSQ_TAB[TAB_AW'(r1_i)];
            r2_tb  <= RSQ_TAB[TAB_AW'(r1_i) + TAB_AW'(1)];
        end
    end

    always_comb begin
        w_up   = r2_tb >= r2_ta;
        w_diff = w_up ? (r2_tb - r2_ta) : (r2_ta - r2_tb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_itm <= r2_itm;
            r3_up  <= w_up;
            r3_ta  <= r2_ta;
            r3_p   <= 32'((63'(w_diff) * 63'(r2_r)) >> 30);
        end
    end

    // divide by 3 by reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_itm <= r3_itm;
            r4_up  <= r3_up;
            r4_ta  <= r3_ta;
            r4_q3  <= 32'((64'(r3_p) * 64'h0_AAAA_AAAB) >> 33);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_itm <= r4_itm;
            r5_rs  <= r4_up ? (r4_ta + 31'(r4_q3)) : (r4_ta - 31'(r4_q3));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_itm <= r5_itm;
            r6_rs  <= r5_rs;
            r6_c1  <= 31'((62'(r5_rs) * 62'(r5_rs)) >> 30);
            r6_av  <= 47'(r5_itm.ax) * 47'(r5_rs);
        end
    end

    always_comb begin
        w_k3   = 5'(r6_itm.k) * 5'd3;
        w_c2   = (62'(r6_c1) * 62'(r6_rs)) >> 30;
        n7_itm = r6_itm;
        if (r6_itm.der) begin
            n7_itm.imag = 40'(w_c2 >> w_k3);
        end else begin
            n7_itm.imag = 40'(r6_av >> (5'(FRAC_BITS) + 5'(r6_itm.k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_itm <= n7_itm;
        end
    end

    assign o_vld  = r_vld[6];
    assign o_item = r7_itm;

endmodule

### rtl/afu_back.sv
// Back end: per-function operand select, one multiply, round and saturate.
// Three register stages, the last is the output register; uses afu_pkg.
module afu_back import afu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  t_item              i_item,
    input  logic [3:0]         i_fsel,
    input  logic [14:0]        i_alpha,
    output logic               o_vld,
    output logic signed [15:0] o_y_value,
    output logic               o_saturated
);

    localparam logic [1:0] SH_DIRECT = 2'd0;
    localparam logic [1:0] SH_R30    = 2'd1;
    localparam logic [1:0] SH_R12    = 2'd2;
    localparam logic [1:0] SH_L6     = 2'd3;

    logic [2:0] r_vld;

    logic [30:0] n1_a, n1_b, r1_a, r1_b;
    logic [1:0]  n1_sh, r1_sh;
    logic [39:0] n1_dmag, r1_dmag;
    logic        n1_psub, r1_psub, n1_rneg, r1_rneg;
    logic [14:0] w_slope;
    logic [39:0] w_axq;

    logic [61:0] w_p;
    logic [39:0] r2_mag;
    logic        r2_psub, r2_rneg;

    logic [39:0] w_mm;
    logic [22:0] w_rnd;
    logic [15:0] r3_y;
    logic        r3_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_comb begin
        n1_a    = '0;
        n1_b    = '0;
        n1_sh   = SH_DIRECT;
        n1_dmag = '0;
        n1_psub = 1'b0;
        n1_rneg = 1'b0;
        w_slope = (i_fsel == FN_LEAKY) ? LEAKY_SLOPE : i_alpha;
        w_axq   = 40'(i_item.ax) << SH_Q;
        case (i_fsel)
            FN_SIG: begin
                if (i_item.der) begin
                    n1_a  = i_item.q;
                    n1_b  = ONE_Q30 - i_item.q;
                    n1_sh = SH_R30;
                end else begin
                    n1_dmag = 40'(i_item.neg ? (ONE_Q30 - i_item.q) : i_item.q);
                end
            end
            FN_TANH: begin
                if (i_item.der) begin
                    n1_a    = i_item.tval;
                    n1_b    = i_item.tval;
                    n1_sh   = SH_R30;
                    n1_psub = 1'b1;
                end else begin
                    n1_dmag = 40'(i_item.tval);
                    n1_rneg = i_item.neg;
                end
            end
            FN_ATAN: begin
                if (i_item.der) begin
                    n1_dmag = 40'(i_item.q);
                end else begin
                    n1_dmag = 40'(i_item.tval);
                    n1_rneg = i_item.neg;
                end
            end
            FN_SOFT: begin
                if (i_item.der) begin
                    n1_a  = i_item.q;
                    n1_b  = i_item.q;
                    n1_sh = SH_R30;
                end else begin
                    n1_dmag = 40'(ONE_Q30 - i_item.q);
                    n1_rneg = i_item.neg;
                end
            end
            FN_ISRU: begin
                n1_dmag = i_item.imag;
                n1_rneg = i_item.neg & ~i_item.der;
            end
            FN_RELU: begin
                if (i_item.neg)      n1_dmag = '0;
                else if (i_item.der) n1_dmag = 40'(ONE_Q30);
                else                 n1_dmag = w_axq;
            end
            FN_LEAKY, FN_PRELU: begin
                if (!i_item.neg) begin
                    n1_dmag = i_item.der ? 40'(ONE_Q30) : w_axq;
                end else if (i_item.der) begin
                    n1_dmag = 40'(w_slope) << SH_Q;
                end else begin
                    n1_a    = 31'(i_item.ax);
                    n1_b    = 31'(w_slope);
                    n1_sh   = SH_L6;
                    n1_rneg = 1'b1;
                end
            end
            FN_ELU: begin
                if (!i_item.neg) begin
                    n1_dmag = i_item.der ? 40'(ONE_Q30) : w_axq;
                end else begin
                    n1_a    = 31'(i_alpha);
                    n1_b    = i_item.der ? i_item.tval : (ONE_Q30 - i_item.tval);
                    n1_sh   = SH_R12;
                    n1_rneg = ~i_item.der;
                end
            end
            FN_SELU: begin
                if (!i_item.neg) begin
                    if (i_item.der) begin
                        n1_dmag = 40'(SELU_LAM);
                    end else begin
                        n1_a  = 31'(i_item.ax);
                        n1_b  = SELU_LAM;
                        n1_sh = SH_R12;
                    end
                end else begin
                    n1_a    = SELU_LA;
                    n1_b    = i_item.der ? i_item.tval : (ONE_Q30 - i_item.tval);
                    n1_sh   = SH_R30;
                    n1_rneg = ~i_item.der;
                end
            end
            default: begin
                // identity, also for the unused selector codes
                n1_dmag = i_item.der ? 40'(ONE_Q30) : w_axq;
                n1_rneg = i_item.neg & ~i_item.der;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a    <= n1_a;
            r1_b    <= n1_b;
            r1_sh   <= n1_sh;
            r1_dmag <= n1_dmag;
            r1_psub <= n1_psub;
            r1_rneg <= n1_rneg;
        end
    end

    assign w_p = 62'(r1_a) * 62'(r1_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_psub <= r1_psub;
            r2_rneg <= r1_rneg;
            case (r1_sh)
                SH_R30:  r2_mag <= 40'(w_p >> 30);
                SH_R12:  r2_mag <= 40'(w_p >> FRAC_BITS);
                SH_L6:   r2_mag <= 40'(w_p) << SH_SQ;
                default: r2_mag <= r1_dmag;
            endcase
        end
    end

    // round half away from zero on the magnitude, then clip
    always_comb begin
        w_mm  = r2_psub ? (40'(ONE_Q30) - r2_mag) : r2_mag;
        w_rnd = 23'((41'(w_mm) + (41'd1 << (SH_Q - 1))) >> SH_Q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r2_rneg) begin
                if (w_rnd > 23'd32768) begin
                    r3_y   <= 16'h8000;
                    r3_sat <= 1'b1;
                end else begin
                    r3_y   <= 16'd0 - w_rnd[15:0];
                    r3_sat <= 1'b0;
                end
            end else begin
                if (w_rnd > 23'd32767) begin
                    r3_y   <= 16'h7FFF;
                    r3_sat <= 1'b1;
                end else begin
                    r3_y   <= w_rnd[15:0];
                    r3_sat <= 1'b0;
                end
            end
        end
    end

    assign o_vld       = r_vld[2];
    assign o_y_value   = r3_y;
    assign o_saturated = r3_sat;

endmodule

### rtl/activation_function_unit.sv
// Pipeline from input transfer to result: 3 front, 31 divider, 7 ISRU and
// 3 back stages; throughput one item per cycle while the output is not stalled.
// The 31-stage quotient pipeline sets the depth; the whole pipe advances
// together whenever the output register is empty or being taken.
// Reset (synchronous, active low) empties the pipe and restores
// function_select to sigmoid and alpha to 1.0.
module activation_function_unit import afu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_x_value,
    input  logic               i_want_derivative,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_y_value,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data
);

    logic [3:0]        r_fsel;
    logic [14:0]       r_alpha;
    logic              w_en;
    logic              w_f_vld, w_d_vld, w_i_vld;
    t_item             w_f_item, w_d_item, w_i_item;
    logic [DIV_DW-1:0] w_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel  <= FN_SIG;
            r_alpha <= 15'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FSEL:  r_fsel  <= i_cfg_data[3:0];
                CFG_ALPHA: r_alpha <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign w_en    = ~o_valid | i_ready;
    assign o_ready = w_en;

    afu_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_vld             (i_valid),
        .i_x_value         (i_x_value),
        .i_want_derivative (i_want_derivative),
        .i_fsel            (r_fsel),
        .i_alpha           (r_alpha),
        .o_vld             (w_f_vld),
        .o_item            (w_f_item),
        .o_divisor         (w_divisor)
    );

    afu_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_vld     (w_f_vld),
        .i_item    (w_f_item),
        .i_divisor (w_divisor),
        .o_vld     (w_d_vld),
        .o_item    (w_d_item)
    );

    afu_isru u_isru (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d_vld),
        .i_item  (w_d_item),
        .o_vld   (w_i_vld),
        .o_item  (w_i_item)
    );

    afu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (w_i_vld),
        .i_item      (w_i_item),
        .i_fsel      (r_fsel),
        .i_alpha     (r_alpha),
        .o_vld       (o_valid),
        .o_y_value   (o_y_value),
        .o_saturated (o_saturated)
    );

endmodule

### rtl/afu_checker.sv
// Port-level checks for activation_function_unit, attached by bind.
// No package dependency.
module afu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_in_ready,
    input logic signed [15:0] i_y_value,
    input logic               i_saturated
);

    // a held result keeps its value until the transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_y_value) && $stable(i_saturated))
        else $error("result changed while stalled");

    // input side is only blocked by a stalled result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input blocked without output stall");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |->
            (i_y_value == 16'sh7FFF) || (i_y_value == 16'sh8000))
        else $error("saturation flag without clipped value");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind activation_function_unit afu_checker u_afu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_in_ready  (o_ready),
    .i_y_value   (o_y_value),
    .i_saturated (o_saturated)
);

### tb/tb_top.sv
// Self-checking testbench for activation_function_unit: random and directed
// x values under every selector, checked against an in-bench Q30 predictor.
// Depends on afu_pkg (function and register codes) and the RTL top.
`timescale 1ns / 100ps

module tb_top;
    import afu_pkg::*;

    localparam int N_PTS = 256;
    localparam logic [63:0] ONE = 64'd1 << 30;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [15:0] x;
        logic        der;
    } t_act_in;

    typedef struct {
        logic [15:0] y;
        logic        sat;
    } t_act_out;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_x_value;
    logic               i_want_derivative;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_y_value;
    logic               o_saturated;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [14:0]        i_cfg_data;

    activation_function_unit dut (.*);

    logic [63:0] exp_pts [0:N_PTS];
    logic [63:0] tanh_pts [0:N_PTS];
    logic [63:0] atan_pts [0:N_PTS];
    logic [63:0] rsq_pts [0:N_PTS];

    t_act_in  pending_q [$];
    t_act_out expected_q [$];
    logic [3:0]  cur_fsel;
    logic [14:0] cur_alpha;
    int errors;
    int cycles;
    int hold_off;
    bit in_taken;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // e^-u by halving until u <= 0.5, a series, then repeated squaring
    function automatic logic [63:0] exp_neg(input logic [63:0] u);
        logic [63:0] v, acc, t;
        int sc;
        sc = 0;
        while ((u >> sc) > (ONE >> 1)) sc++;
        v = u >> sc;
        acc = ONE;
        t = ONE;
        for (int n = 1; n <= 20; n++) begin
            t = ((t * v) >> 30) / 64'(n);
            if (n % 2 == 1) acc = acc - t;
            else acc = acc + t;
        end
        repeat (sc) acc = (acc * acc) >> 30;
        return acc;
    endfunction

    function automatic logic [63:0] arctan_q30(input logic [63:0] a_in);
        logic [63:0] a, z2, p, acc;
        logic flip;
        a = a_in;
        flip = a > ONE;
        if (flip) a = (ONE << 30) / a;
        repeat (2) a = (a << 30) / (ONE + int_sqrt((ONE << 30) + a * a));
        z2 = (a * a) >> 30;
        p = a;
        acc = a;
        for (int n = 1; n <= 10; n++) begin
            p = (p * z2) >> 30;
            if (n % 2 == 1) acc = acc - p / 64'(2 * n + 1);
            else acc = acc + p / 64'(2 * n + 1);
        end
        acc = acc << 2;
        return flip ? 64'(HALF_PI) - acc : acc;
    endfunction

    function automatic logic [63:0] interp(input logic [63:0] tab [0:N_PTS],
                                           input logic [63:0] pos,
                                           input logic [63:0] den);
        logic [63:0] i, r;
        i = pos / den;
        r = pos % den;
        if (i >= N_PTS) return tab[N_PTS];
        if (tab[i+1] >= tab[i]) return tab[i] + (tab[i+1] - tab[i]) * r / den;
        return tab[i] - (tab[i] - tab[i+1]) * r / den;
    endfunction

    function automatic t_act_out activation_result(input logic [15:0] raw,
                                                   input logic der,
                                                   input logic [3:0] fsel,
                                                   input logic [14:0] alpha);
        logic [63:0] ax, mag, al, tpos, e, s, m, rs, c, r, q;
        logic neg, rneg;
        int k;
        t_act_out res;
        neg = raw[15];
        rneg = 1'b0;
        al = 64'(alpha);
        ax = neg ? 64'd65536 - 64'(raw) : 64'(raw);
        tpos = ax * N_PTS;
        mag = 0;
        case (fsel)
            FN_SIG: begin
                e = interp(exp_pts, tpos, 32768);
                s = (ONE << 30) / (ONE + e);
                if (der) mag = (s * (ONE - s)) >> 30;
                else mag = neg ? ONE - s : s;
            end
            FN_TANH: begin
                e = interp(tanh_pts, tpos, 32768);
                if (der) mag = ONE - ((e * e) >> 30);
                else begin
                    mag = e;
                    rneg = neg;
                end
            end
            FN_ATAN: begin
                if (der) mag = (ONE << 30) / (ONE + ((ax * ax) << 6));
                else begin
                    mag = interp(atan_pts, tpos, 32768);
                    rneg = neg;
                end
            end
            FN_SOFT: begin
                r = (64'd1 << 42) / (64'd4096 + ax);
                if (der) mag = (r * r) >> 30;
                else begin
                    mag = ONE - r;
                    rneg = neg;
                end
            end
            FN_ISRU: begin
                s = ONE + ((al * ax * ax) >> 6);
                k = 0;
                while ((s >> (2 * k)) >= (ONE << 2)) k++;
                m = s >> (2 * k);
                rs = interp(rsq_pts, (m - ONE) * N_PTS, 3 * ONE);
                if (der) begin
                    c = (rs * rs) >> 30;
                    c = (c * rs) >> 30;
                    mag = c >> (3 * k);
                end else begin
                    mag = (ax * rs) >> (12 + k);
                    rneg = neg;
                end
            end
            FN_RELU: begin
                if (der) mag = neg ? 0 : ONE;
                else mag = neg ? 0 : ax << 18;
            end
            FN_LEAKY, FN_PRELU: begin
                q = (fsel == FN_LEAKY) ? 64'(LEAKY_SLOPE) : al;
                if (!neg) mag = der ? ONE : ax << 18;
                else if (der) mag = q << 18;
                else begin
                    mag = (ax * q) << 6;
                    rneg = 1'b1;
                end
            end
            FN_ELU: begin
                if (!neg) mag = der ? ONE : ax << 18;
                else begin
                    e = interp(exp_pts, tpos, 32768);
                    if (der) mag = (al * e) >> 12;
                    else begin
                        mag = (al * (ONE - e)) >> 12;
                        rneg = 1'b1;
                    end
                end
            end
            FN_SELU: begin
                if (!neg) mag = der ? 64'(SELU_LAM) : (ax * 64'(SELU_LAM)) >> 12;
                else begin
                    e = interp(exp_pts, tpos, 32768);
                    if (der) mag = (64'(SELU_LA) * e) >> 30;
                    else begin
                        mag = (64'(SELU_LA) * (ONE - e)) >> 30;
                        rneg = 1'b1;
                    end
                end
            end
            default: begin
                if (der) mag = ONE;
                else begin
                    mag = ax << 18;
                    rneg = neg;
                end
            end
        endcase
        mag = (mag + (64'd1 << 17)) >> 18;
        res.sat = 1'b0;
        if (rneg) begin
            if (mag > 32768) begin
                mag = 32768;
                res.sat = 1'b1;
            end
            res.y = 16'(64'd65536 - mag);
        end else begin
            if (mag > 32767) begin
                mag = 32767;
                res.sat = 1'b1;
            end
            res.y = mag[15:0];
        end
        return res;
    endfunction

    task automatic report(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // input side: note each transfer and predict its result
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_valid && o_ready) begin
            expected_q.push_back(activation_result(i_x_value, i_want_derivative,
                                                   cur_fsel, cur_alpha));
            in_taken = 1'b1;
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_act_out ex;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report("result with nothing expected");
            end else begin
                ex = expected_q.pop_front();
                if (o_y_value !== ex.y)
                    report($sformatf("y %h, expected %h", o_y_value, ex.y));
                if (o_saturated !== ex.sat)
                    report($sformatf("sat %b, expected %b", o_saturated, ex.sat));
            end
        end
    end

    // sender: bursts separated by random gaps
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        logic nv;
        t_act_in it;
        nv = i_valid;
        if (!i_valid || in_taken) begin
            nv = 1'b0;
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0) begin
                it = pending_q.pop_front();
                i_x_value <= it.x;
                i_want_derivative <= it.der;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_valid <= nv;
    end

    // receiver: stalls at a density redrawn at random from 0, 25, 50 and 75 percent
    int stall_pct;
    always @(negedge i_clk) begin
        if (cycles % 256 == 0) stall_pct = $urandom_range(0, 3) * 25;
        if (hold_off > 0) begin
            hold_off--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_FSEL) cur_fsel = val[3:0];
        else if (idx == CFG_ALPHA) cur_alpha = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_item(input logic [15:0] x, input logic der);
        t_act_in it;
        it.x = x;
        it.der = der;
        pending_q.push_back(it);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    logic [15:0] edge_x [0:7] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001,
                                  16'h7FFF, 16'h1000, 16'hF000, 16'h5555};
    initial begin
        logic [3:0] fs;
        logic [14:0] al;
        for (int i = 0; i <= N_PTS; i++) begin
            logic [63:0] u, e, e2, m;
            u = (64'(i) << 33) / N_PTS;
            e = exp_neg(u);
            exp_pts[i] = e;
            e2 = (e * e) >> 30;
            tanh_pts[i] = ((ONE - e2) << 30) / (ONE + e2);
            atan_pts[i] = arctan_q30(u);
            m = ONE + (3 * ONE * 64'(i)) / N_PTS;
            rsq_pts[i] = (ONE << 30) / int_sqrt(m << 30);
        end
        errors = 0;
        cycles = 0;
        hold_off = 0;
        burst_left = 0;
        gap_left = 0;
        stall_pct = 0;
        in_taken = 1'b0;
        cur_fsel = FN_SIG;
        cur_alpha = 15'd4096;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_x_value = '0;
        i_want_derivative = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_FSEL;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first: field extremes, both outputs kinds
        for (int i = 0; i < 8; i++) begin
            push_item(edge_x[i], 1'b0);
            push_item(edge_x[i], 1'b1);
        end
        drain();

        for (int p = 0; p < 24; p++) begin
            fs = (p < 16) ? 4'(p) : 4'($urandom_range(0, 10));
            case (p % 4)
                0: al = 15'd0;
                1: al = 15'h7FFF;
                default: al = 15'($urandom);
            endcase
            write_reg(CFG_FSEL, fs);
            write_reg(CFG_ALPHA, al);
            // spare indexes must be ignored
            if (p % 3 == 0) write_reg(($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B),
                                      15'($urandom));
            if (p == 6) hold_off = 400;
            for (int i = 0; i < 80; i++) begin
                case ($urandom_range(0, 9))
                    0: push_item(edge_x[$urandom_range(0, 7)], 1'($urandom));
                    1, 2, 3: push_item(16'($urandom), 1'($urandom));
                    default: push_item(16'($signed($urandom_range(0, 32767)) - 16384),
                                       1'($urandom));
                endcase
            end
            drain();
        end

        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/afu_pkg.sv
rtl/afu_front.sv
rtl/afu_div.sv
rtl/afu_isru.sv
rtl/afu_back.sv
rtl/activation_function_unit.sv
rtl/afu_checker.sv
tb/tb_top.sv
